// ----- design/mhd_pkg.sv -----
// ----------------------------------------------------------------------------
// mhd_pkg
// shared constants, types and the arctangent table of the m-psk demapper
// ----------------------------------------------------------------------------
package mhd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int PHASE_WIDTH_DEF  = 16;

  // angle accumulator: 2^32 units per full turn
  localparam int ACC_W = 32;

  // symbol index and bits-per-symbol register
  localparam int                SYM_W     = 6;
  localparam int                BPS_W     = 3;
  localparam logic [BPS_W-1:0] BPS_RESET = 3'd2;
  localparam logic [BPS_W-1:0] BPS_MIN   = 3'd1;
  localparam logic [BPS_W-1:0] BPS_MAX   = 3'd6;

  // control that travels with each word through the pipeline
  typedef struct packed {
    logic valid;
    logic zero;   // sample at the origin, phase forced to zero
  } stage_ctrl_t;

  // atan(2^-i) in turns scaled by 2^32, rounded to nearest
  function automatic logic [ACC_W-1:0] atan_turns(input logic [4:0] idx);
    logic [ACC_W-1:0] val;
    unique case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      5'd30:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// ----- design/mpsk_hard_decision.sv -----
// ----------------------------------------------------------------------------
// mpsk_hard_decision
// m-psk hard-decision demapper: cordic phase, then phase-sector decision
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one i/q sample per word: in_phase in the low
//   SAMPLE_WIDTH bits of tdata, quadrature in the next SAMPLE_WIDTH bits.
//   m_axis returns one word per sample: symbol_index in tdata[5:0].
//   cfg_we_i/cfg_wdata_i write bits_per_symbol (M = 2^bits_per_symbol);
//   write it only while no sample is in flight. 0 acts as 1, 7 as 6.
// throughput and pipeline:
//   one sample per clock while s_axis_tready is high. a sample passes
//   through one input stage, PHASE_WIDTH+2 cordic iteration stages, a
//   rounding stage, a sector stage and the output register.
// reset:
//   all valid bits (pipeline, output, skid slot) are cleared, bits_per_symbol
//   returns to 2 (qpsk).
// stall:
//   a result waiting on m_axis does not block the input; a second one
//   drops into a skid slot, and only then does s_axis_tready fall and
//   the whole pipeline hold. nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mpsk_hard_decision #(
  parameter int SAMPLE_WIDTH = mhd_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = mhd_pkg::PHASE_WIDTH_DEF,
  parameter int S_TDATA_W    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: bits_per_symbol
  input  logic                      cfg_we_i,
  input  logic [mhd_pkg::BPS_W-1:0] cfg_wdata_i,
  // sample stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [S_TDATA_W-1:0]      s_axis_tdata,   // in_phase, quadrature, zero pad
  // symbol stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata    // symbol_index, zero pad
);
  import mhd_pkg::*;

  localparam int DP_W  = SAMPLE_WIDTH + PHASE_WIDTH + 5;  // headroom for gain and fold
  localparam int NITER = PHASE_WIDTH + 2;

  logic [BPS_W-1:0] bps_q;
  logic             en;       // whole pipeline advances together
  logic             dec_valid;
  logic [SYM_W-1:0] dec_sym, out_sym;

  stage_ctrl_t            ctrl_s [0:NITER];
  logic signed [DP_W-1:0] x_s    [0:NITER];
  logic signed [DP_W-1:0] y_s    [0:NITER];
  logic [ACC_W-1:0]       acc_s  [0:NITER];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= BPS_RESET;
    end else if (cfg_we_i) begin
      bps_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = en;

  // scale, fold left half plane, flag the origin
  mhd_input_stage #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH),
    .DP_W         (DP_W)
  ) u_input (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid),
    .in_phase_i   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .quadrature_i (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .ctrl_o       (ctrl_s[0]),
    .x_o          (x_s[0]),
    .y_o          (y_s[0]),
    .acc_o        (acc_s[0])
  );

  // one register stage per cordic iteration
  for (genvar g = 0; g < NITER; g++) begin : g_cordic
    mhd_cordic_stage #(
      .DP_W   (DP_W),
      .IDX    (g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .acc_i  (acc_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .acc_o  (acc_s[g+1])
    );
  end

  // rounding and sector decision
  mhd_decide #(
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .bps_i   (bps_q),
    .ctrl_i  (ctrl_s[NITER]),
    .acc_i   (acc_s[NITER]),
    .valid_o (dec_valid),
    .sym_o   (dec_sym)
  );

  // output register plus skid slot
  mhd_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .data_i  (dec_sym),
    .ready_o (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_sym)
  );

  assign m_axis_tdata = {{(8-SYM_W){1'b0}}, out_sym};

endmodule

// ----- design/mhd_input_stage.sv -----
// ----------------------------------------------------------------------------
// mhd_input_stage
// scales the i/q sample, folds the left half plane and registers the result
// ----------------------------------------------------------------------------
module mhd_input_stage #(
  parameter int SAMPLE_WIDTH = mhd_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = mhd_pkg::PHASE_WIDTH_DEF,
  parameter int DP_W         = SAMPLE_WIDTH + PHASE_WIDTH + 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [SAMPLE_WIDTH-1:0]   in_phase_i,
  input  logic [SAMPLE_WIDTH-1:0]   quadrature_i,
  output mhd_pkg::stage_ctrl_t      ctrl_o,
  output logic signed [DP_W-1:0]    x_o,
  output logic signed [DP_W-1:0]    y_o,
  output logic [mhd_pkg::ACC_W-1:0] acc_o
);
  import mhd_pkg::*;

  logic signed [DP_W-1:0] xs, ys;
  logic signed [DP_W-1:0] x_d, y_d, x_q, y_q;
  logic [ACC_W-1:0]       acc_d, acc_q;
  stage_ctrl_t            ctrl_d, ctrl_q;

  always_comb begin
    xs = {{(DP_W-SAMPLE_WIDTH){in_phase_i[SAMPLE_WIDTH-1]}}, in_phase_i};
    ys = {{(DP_W-SAMPLE_WIDTH){quadrature_i[SAMPLE_WIDTH-1]}}, quadrature_i};
    xs = xs <<< (PHASE_WIDTH + 2);
    ys = ys <<< (PHASE_WIDTH + 2);
    // left half plane: rotate by half a turn
    if (xs < 0) begin
      x_d   = -xs;
      y_d   = -ys;
      acc_d = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      x_d   = xs;
      y_d   = ys;
      acc_d = '0;
    end
    ctrl_d.valid = valid_i;
    ctrl_d.zero  = (in_phase_i == '0) && (quadrature_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign acc_o  = acc_q;

endmodule

// ----- design/mhd_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// mhd_cordic_stage
// one registered cordic vectoring iteration
// ----------------------------------------------------------------------------
module mhd_cordic_stage #(
  parameter int DP_W = 37,
  parameter int IDX  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  mhd_pkg::stage_ctrl_t      ctrl_i,
  input  logic signed [DP_W-1:0]    x_i,
  input  logic signed [DP_W-1:0]    y_i,
  input  logic [mhd_pkg::ACC_W-1:0] acc_i,
  output mhd_pkg::stage_ctrl_t      ctrl_o,
  output logic signed [DP_W-1:0]    x_o,
  output logic signed [DP_W-1:0]    y_o,
  output logic [mhd_pkg::ACC_W-1:0] acc_o
);
  import mhd_pkg::*;

  localparam logic [ACC_W-1:0] ATAN = atan_turns(5'(IDX));

  logic signed [DP_W-1:0] x_sh, y_sh, x_d, y_d, x_q, y_q;
  logic [ACC_W-1:0]       acc_d, acc_q;
  stage_ctrl_t            ctrl_q;

  always_comb begin
    x_sh = x_i >>> IDX;
    y_sh = y_i >>> IDX;
    // rotate toward the positive x axis
    if (!y_i[DP_W-1]) begin
      x_d   = x_i + y_sh;
      y_d   = y_i - x_sh;
      acc_d = acc_i + ATAN;
    end else begin
      x_d   = x_i - y_sh;
      y_d   = y_i + x_sh;
      acc_d = acc_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign acc_o  = acc_q;

endmodule

// ----- design/mhd_decide.sv -----
// ----------------------------------------------------------------------------
// mhd_decide
// rounds the angle to phase_width bits, then picks the m-psk sector
// ----------------------------------------------------------------------------
module mhd_decide #(
  parameter int PHASE_WIDTH = mhd_pkg::PHASE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [mhd_pkg::BPS_W-1:0] bps_i,
  input  mhd_pkg::stage_ctrl_t      ctrl_i,
  input  logic [mhd_pkg::ACC_W-1:0] acc_i,
  output logic                      valid_o,
  output logic [mhd_pkg::SYM_W-1:0] sym_o
);
  import mhd_pkg::*;

  localparam logic [ACC_W-1:0]       RND = ACC_W'(1) << (ACC_W - 1 - PHASE_WIDTH);
  localparam logic [PHASE_WIDTH-1:0] ONE = PHASE_WIDTH'(1);

  logic [ACC_W-1:0]       acc_r;
  logic [PHASE_WIDTH-1:0] ph_d, ph_q, half_m1, t;
  logic [4:0]             sh;
  logic [BPS_W-1:0]       bps_c, top_sh;
  logic [SYM_W-1:0]       top, sym_d, sym_q;
  logic                   v1_q, v2_q;

  // stage one: round half up
  always_comb begin
    acc_r = acc_i + RND;
    ph_d  = ctrl_i.zero ? '0 : acc_r[ACC_W-1 -: PHASE_WIDTH];
  end

  // stage two: sector of width 2^(phase_width - bps), centered on zero
  always_comb begin
    if (bps_i < BPS_MIN) begin
      bps_c = BPS_MIN;
    end else if (bps_i > BPS_MAX) begin
      bps_c = BPS_MAX;
    end else begin
      bps_c = bps_i;
    end
    sh      = 5'(PHASE_WIDTH) - {2'b00, bps_c};
    half_m1 = (ONE << (sh - 5'd1)) - ONE;
    t       = ph_q + half_m1;
    top     = t[PHASE_WIDTH-1 -: SYM_W];
    top_sh  = 3'(SYM_W) - bps_c;
    sym_d   = top >> top_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= ctrl_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q  <= ph_d;
      sym_q <= sym_d;
    end
  end

  assign valid_o = v2_q;
  assign sym_o   = sym_q;

endmodule

// ----- design/mhd_out_skid.sv -----
// ----------------------------------------------------------------------------
// mhd_out_skid
// output register with a skid slot, parts the pipeline from the receiver
// ----------------------------------------------------------------------------
module mhd_out_skid (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [mhd_pkg::SYM_W-1:0] data_i,
  output logic                      ready_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [mhd_pkg::SYM_W-1:0] data_o
);
  import mhd_pkg::*;

  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic [SYM_W-1:0] out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic             take;

  always_comb begin
    take         = ready_o && valid_i;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = take;
        out_data_d  = data_i;
      end
    end else if (take) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule
